// File: design/sorted_refcounted_key_table_core_assert.svh
// Assertion macros for the sorted key table core.
`ifndef SORTED_REFCOUNTED_KEY_TABLE_CORE_ASSERT_SVH
`define SORTED_REFCOUNTED_KEY_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SRKT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted key table check failed");
`define SRKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key table check failed");
`else
`define SRKT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SRKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/srkt_pkg.sv
// Types and constants shared by the sorted key table core and its cells.
`timescale 1ns / 1ps
`default_nettype none

package srkt_pkg;

    localparam int TID_W    = 64;
    localparam int VER_W    = 63;
    localparam int HND_W    = 48;
    localparam int S_DATA_W = 176;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 4;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_ADD     = 2'd1,
        OP_RELEASE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_FULL      = 3'd2,
        ST_EXISTS    = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_REFS      = 3'd5,
        ST_SAT       = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        M_SEARCH = 3'd0,
        M_CARRY  = 3'd1,
        M_SHIFT  = 3'd2,
        M_CLEAR  = 3'd3,
        M_DONE   = 3'd4
    } t_mode;

    typedef struct packed {
        logic    vld;
        t_op     op;
        t_mode   mode;
        t_status status;
        logic    freed;
    } t_ctl;

endpackage

`default_nettype wire

// File: design/srkt_cell.sv
// One table entry of the sorted key table, with its slot of the request chain.
`timescale 1ns / 1ps
`default_nettype none

module srkt_cell import srkt_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int REF_WIDTH   = 32,
    parameter int IDX         = 0
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]   i_count,
    input  wire t_ctl                               i_ctl,
    input  wire logic [TID_W-1:0]                   i_tid,
    input  wire logic [VER_W-1:0]                   i_ver,
    input  wire logic [HND_W-1:0]                   i_hnd,
    input  wire logic [REF_WIDTH-1:0]               i_cnt,
    output t_ctl                                    o_ctl,
    output logic [TID_W-1:0]                        o_tid,
    output logic [VER_W-1:0]                        o_ver,
    output logic [HND_W-1:0]                        o_hnd,
    output logic [REF_WIDTH-1:0]                    o_cnt,
    input  wire logic [TID_W-1:0]                   i_nb_tid,
    input  wire logic [VER_W-1:0]                   i_nb_ver,
    input  wire logic [HND_W-1:0]                   i_nb_hnd,
    input  wire logic [REF_WIDTH-1:0]               i_nb_cnt,
    output logic [TID_W-1:0]                        o_e_tid,
    output logic [VER_W-1:0]                        o_e_ver,
    output logic [HND_W-1:0]                        o_e_hnd,
    output logic [REF_WIDTH-1:0]                    o_e_cnt
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_ctl                 r_ctl, n_ctl;
    logic [TID_W-1:0]     r_tid, n_tid, r_e_tid, n_e_tid;
    logic [VER_W-1:0]     r_ver, n_ver, r_e_ver, n_e_ver;
    logic [HND_W-1:0]     r_hnd, n_hnd, r_e_hnd, n_e_hnd;
    logic [REF_WIDTH-1:0] r_cnt, n_cnt, r_e_cnt, n_e_cnt;
    logic                 w_valid, w_eq, w_gt;

    assign w_valid = i_count > CW'(IDX);
    assign w_eq    = w_valid && (r_e_tid == i_tid) && (r_e_ver == i_ver);
    assign w_gt    = w_valid && ((r_e_tid > i_tid) || ((r_e_tid == i_tid) && (r_e_ver > i_ver)));

    always_comb begin
        n_ctl   = i_ctl;
        n_tid   = i_tid;
        n_ver   = i_ver;
        n_hnd   = i_hnd;
        n_cnt   = i_cnt;
        n_e_tid = r_e_tid;
        n_e_ver = r_e_ver;
        n_e_hnd = r_e_hnd;
        n_e_cnt = r_e_cnt;
        if (i_ctl.vld) begin
            case (i_ctl.mode)
                M_SEARCH: begin
                    case (i_ctl.op)
                        OP_ADD: begin
                            if (w_eq) begin
                                n_ctl.status = ST_EXISTS;
                                n_ctl.mode   = M_DONE;
                            end else if (!w_valid || w_gt) begin
                                n_e_tid    = i_tid;
                                n_e_ver    = i_ver;
                                n_e_hnd    = i_hnd;
                                n_e_cnt    = REF_WIDTH'(1);
                                n_tid      = r_e_tid;
                                n_ver      = r_e_ver;
                                n_hnd      = r_e_hnd;
                                n_cnt      = r_e_cnt;
                                n_ctl.mode = w_valid ? M_CARRY : M_DONE;
                            end
                        end
                        OP_GET: begin
                            if (w_eq) begin
                                n_ctl.mode = M_DONE;
                                if (r_e_cnt == '1) begin
                                    n_ctl.status = ST_SAT;
                                end else begin
                                    n_e_cnt      = r_e_cnt + REF_WIDTH'(1);
                                    n_hnd        = r_e_hnd;
                                    n_ctl.status = ST_OK;
                                end
                            end
                        end
                        OP_RELEASE: begin
                            if (w_eq) begin
                                n_ctl.mode = M_DONE;
                                if (r_e_cnt == '0) begin
                                    n_ctl.status = ST_SAT;
                                end else if (r_e_cnt == REF_WIDTH'(1)) begin
                                    n_e_tid      = i_nb_tid;
                                    n_e_ver      = i_nb_ver;
                                    n_e_hnd      = i_nb_hnd;
                                    n_e_cnt      = i_nb_cnt;
                                    n_hnd        = r_e_hnd;
                                    n_ctl.freed  = 1'b1;
                                    n_ctl.status = ST_OK;
                                    n_ctl.mode   = M_SHIFT;
                                end else begin
                                    n_e_cnt      = r_e_cnt - REF_WIDTH'(1);
                                    n_ctl.status = ST_OK;
                                end
                            end
                        end
                        default: begin
                            n_ctl.mode = M_DONE;
                        end
                    endcase
                end
                M_CARRY: begin
                    n_e_tid = i_tid;
                    n_e_ver = i_ver;
                    n_e_hnd = i_hnd;
                    n_e_cnt = i_cnt;
                    n_tid   = r_e_tid;
                    n_ver   = r_e_ver;
                    n_hnd   = r_e_hnd;
                    n_cnt   = r_e_cnt;
                    if (!w_valid) begin
                        n_ctl.mode = M_DONE;
                    end
                end
                M_SHIFT: begin
                    n_e_tid = i_nb_tid;
                    n_e_ver = i_nb_ver;
                    n_e_hnd = i_nb_hnd;
                    n_e_cnt = i_nb_cnt;
                end
                M_CLEAR: begin
                    if (w_valid && (r_e_cnt != '0)) begin
                        n_ctl.status = ST_REFS;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tid   <= n_tid;
        r_ver   <= n_ver;
        r_hnd   <= n_hnd;
        r_cnt   <= n_cnt;
        r_e_tid <= n_e_tid;
        r_e_ver <= n_e_ver;
        r_e_hnd <= n_e_hnd;
        r_e_cnt <= n_e_cnt;
    end

    assign o_ctl   = r_ctl;
    assign o_tid   = r_tid;
    assign o_ver   = r_ver;
    assign o_hnd   = r_hnd;
    assign o_cnt   = r_cnt;
    assign o_e_tid = r_e_tid;
    assign o_e_ver = r_e_ver;
    assign o_e_hnd = r_e_hnd;
    assign o_e_cnt = r_e_cnt;

endmodule

`default_nettype wire

// File: design/sorted_refcounted_key_table_core.sv
// Top level of the sorted, reference-counted key table.
//
//   channel   ports          direction  contents
//   request   i_s_t*/o_s_*   in         tuser: operation; tdata: tkey, version, handle
//   result    o_m_t*/i_m_*   out        tuser: status, freed; tdata: handle_out
//
// A request walks the chain of TABLE_DEPTH cells, one cell per cycle, and its result
// is registered at the output; one request is in the chain at a time, so a new request
// is taken only after the last one has left the chain.
// A new request is taken as soon as the chain is free, even while a result waits.
// A result that meets a full output register waits in a hold register, which stops intake.
// Reset empties the table at once through the entry count; entries need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_refcounted_key_table_core_assert.svh"

module sorted_refcounted_key_table_core import srkt_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int REF_WIDTH   = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,   // tkey[63:0], version[127:64], handle[175:128]
    input  wire logic [S_USER_W-1:0] i_s_tuser,   // operation[1:0]
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic [M_DATA_W-1:0]      o_m_tdata,   // handle_out[47:0]
    output logic [M_USER_W-1:0]      o_m_tuser    // status[2:0], freed[3]
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    t_state               r_state;
    t_ctl                 r_tok_ctl, n_launch;
    logic [TID_W-1:0]     r_tok_tid;
    logic [VER_W-1:0]     r_tok_ver;
    logic [HND_W-1:0]     r_tok_hnd;
    logic [REF_WIDTH-1:0] r_tok_cnt;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_out_vld;
    t_status              r_out_status, r_res_status;
    logic [HND_W-1:0]     r_out_hnd, r_res_hnd, w_end_hnd;
    logic                 r_out_freed, r_res_freed;

    t_ctl                 w_ctl   [0:TABLE_DEPTH];
    logic [TID_W-1:0]     w_tid   [0:TABLE_DEPTH];
    logic [VER_W-1:0]     w_ver   [0:TABLE_DEPTH];
    logic [HND_W-1:0]     w_hnd   [0:TABLE_DEPTH];
    logic [REF_WIDTH-1:0] w_cnt   [0:TABLE_DEPTH];
    logic [TID_W-1:0]     w_e_tid [0:TABLE_DEPTH];
    logic [VER_W-1:0]     w_e_ver [0:TABLE_DEPTH];
    logic [HND_W-1:0]     w_e_hnd [0:TABLE_DEPTH];
    logic [REF_WIDTH-1:0] w_e_cnt [0:TABLE_DEPTH];

    t_op                  w_op;
    logic [TID_W-1:0]     w_in_tid;
    logic [63:0]          w_in_ver;
    logic [HND_W-1:0]     w_in_hnd;
    logic                 w_key_bad, w_full, w_accept, w_out_free, w_out_load;
    t_ctl                 w_end_ctl;

    assign w_op     = t_op'(i_s_tuser);
    assign w_in_tid = i_s_tdata[63:0];
    assign w_in_ver = i_s_tdata[127:64];
    assign w_in_hnd = i_s_tdata[175:128];
    assign w_key_bad = (w_in_tid == '0) || (w_in_tid == '1) || w_in_ver[63];
    assign w_full    = r_count == CW'(TABLE_DEPTH);

    assign o_s_tready = r_state == S_IDLE;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_vld || i_m_tready;
    assign w_out_load = w_out_free &&
                        (((r_state == S_RUN) && w_end_ctl.vld) || (r_state == S_HOLD));

    always_comb begin
        n_launch       = '0;
        n_launch.vld   = 1'b1;
        n_launch.op    = w_op;
        n_launch.mode  = M_SEARCH;
        n_launch.status = ST_OK;
        if (w_op == OP_CLEAR) begin
            n_launch.mode = M_CLEAR;
        end else if (w_key_bad || ((w_op == OP_ADD) && (w_in_hnd == '0))) begin
            n_launch.mode   = M_DONE;
            n_launch.status = ST_INVALID;
        end else if (w_op == OP_ADD) begin
            if (w_full) begin
                n_launch.mode   = M_DONE;
                n_launch.status = ST_FULL;
            end
        end else begin
            n_launch.status = ST_NOT_FOUND;
        end
    end

    assign w_ctl[0] = r_tok_ctl;
    assign w_tid[0] = r_tok_tid;
    assign w_ver[0] = r_tok_ver;
    assign w_hnd[0] = r_tok_hnd;
    assign w_cnt[0] = r_tok_cnt;

    assign w_e_tid[TABLE_DEPTH] = '0;
    assign w_e_ver[TABLE_DEPTH] = '0;
    assign w_e_hnd[TABLE_DEPTH] = '0;
    assign w_e_cnt[TABLE_DEPTH] = '0;

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        srkt_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .REF_WIDTH   (REF_WIDTH),
            .IDX         (gi)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_count  (r_count),
            .i_ctl    (w_ctl[gi]),
            .i_tid    (w_tid[gi]),
            .i_ver    (w_ver[gi]),
            .i_hnd    (w_hnd[gi]),
            .i_cnt    (w_cnt[gi]),
            .o_ctl    (w_ctl[gi+1]),
            .o_tid    (w_tid[gi+1]),
            .o_ver    (w_ver[gi+1]),
            .o_hnd    (w_hnd[gi+1]),
            .o_cnt    (w_cnt[gi+1]),
            .i_nb_tid (w_e_tid[gi+1]),
            .i_nb_ver (w_e_ver[gi+1]),
            .i_nb_hnd (w_e_hnd[gi+1]),
            .i_nb_cnt (w_e_cnt[gi+1]),
            .o_e_tid  (w_e_tid[gi]),
            .o_e_ver  (w_e_ver[gi]),
            .o_e_hnd  (w_e_hnd[gi]),
            .o_e_cnt  (w_e_cnt[gi])
        );
    end

    assign w_end_ctl = w_ctl[TABLE_DEPTH];
    assign w_end_hnd = (w_end_ctl.freed ||
                        ((w_end_ctl.op == OP_GET) && (w_end_ctl.status == ST_OK)))
                       ? w_hnd[TABLE_DEPTH] : '0;

    always_comb begin
        n_count = r_count;
        case (w_end_ctl.op)
            OP_CLEAR: n_count = '0;
            OP_ADD: begin
                if (w_end_ctl.status == ST_OK) begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_RELEASE: begin
                if (w_end_ctl.freed) begin
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_tok_ctl     <= '0;
            r_count       <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (!w_accept) begin
                r_tok_ctl.vld <= 1'b0;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_tok_ctl <= n_launch;
                        r_tok_tid <= w_in_tid;
                        r_tok_ver <= w_in_ver[VER_W-1:0];
                        r_tok_hnd <= w_in_hnd;
                        r_tok_cnt <= '0;
                        r_state   <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_end_ctl.vld) begin
                        r_count <= n_count;
                        if (w_out_free) begin
                            r_out_status <= w_end_ctl.status;
                            r_out_hnd    <= w_end_hnd;
                            r_out_freed  <= w_end_ctl.freed;
                            r_state      <= S_IDLE;
                        end else begin
                            r_res_status <= w_end_ctl.status;
                            r_res_hnd    <= w_end_hnd;
                            r_res_freed  <= w_end_ctl.freed;
                            r_state      <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_out_status <= r_res_status;
                        r_out_hnd    <= r_res_hnd;
                        r_out_freed  <= r_res_freed;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_hnd;
    assign o_m_tuser  = {r_out_freed, r_out_status};

    `SRKT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH))
    `SRKT_ASSERT_NEXT(a_launch, i_clk, i_rst_n, w_accept, (r_state == S_RUN) && r_tok_ctl.vld)
    `SRKT_ASSERT_IMP(a_exit_in_run, i_clk, i_rst_n, w_end_ctl.vld, r_state == S_RUN)
    `SRKT_ASSERT_IMP(a_freed_ok, i_clk, i_rst_n, r_out_vld && r_out_freed, r_out_status == ST_OK)

endmodule

`default_nettype wire
